// ===== hw/rtl/tnorm_pkg.sv =====
// Shared widths and pipeline side-band types for the triangle unit normal block.
`default_nettype none
package tnorm_pkg;

  localparam int CW  = 32;
  localparam int EW  = CW + 1;
  localparam int PW  = 2 * EW;
  localparam int MW  = 65;
  localparam int HW  = MW - CW;
  localparam int SQW = 2 * MW;
  localparam int SW  = 132;
  localparam int LW  = SW / 2;
  localparam int RW  = LW + 3;
  localparam int QW  = 31;

  typedef struct packed {
    logic [2:0]          neg;
    logic [2:0][MW-1:0]  mag;
    logic                degen;
  } side_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } dside_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tnorm_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module tnorm_sqrt (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [tnorm_pkg::SW-1:0] in_sq,
  input  tnorm_pkg::side_t         in_side,
  output logic                     out_valid,
  output logic [tnorm_pkg::LW-1:0] out_root,
  output tnorm_pkg::side_t         out_side
);
  import tnorm_pkg::*;

  logic          vld_r  [0:LW];
  logic [RW-1:0] rem_r  [0:LW];
  logic [LW-1:0] root_r [0:LW];
  logic [SW-1:0] sv_r   [0:LW];
  side_t         sd_r   [0:LW];

  assign vld_r[0]  = in_valid;
  assign rem_r[0]  = '0;
  assign root_r[0] = '0;
  assign sv_r[0]   = in_sq;
  assign sd_r[0]   = in_side;

  for (genvar g = 0; g < LW; g++) begin : g_step
    logic [RW-1:0] trial;
    logic [RW-1:0] tst;
    logic          ge;

    assign trial = {rem_r[g][RW-3:0], sv_r[g][SW-1 -: 2]};
    assign tst   = {1'b0, root_r[g], 2'b01};
    assign ge    = (trial >= tst);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else if (en) begin
        vld_r[g+1] <= vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g+1]  <= ge ? (trial - tst) : trial;
        root_r[g+1] <= {root_r[g][LW-2:0], ge};
        sv_r[g+1]   <= {sv_r[g][SW-3:0], 2'b00};
        sd_r[g+1]   <= sd_r[g];
      end
    end
  end

  assign out_valid = vld_r[LW];
  assign out_root  = root_r[LW];
  assign out_side  = sd_r[LW];

endmodule
`default_nettype wire

// ===== hw/rtl/tnorm_div.sv =====
// Pipelined restoring divider, three quotients against one shared divisor.
`default_nettype none
module tnorm_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [2:0][tnorm_pkg::MW-1:0]      in_mag,
  input  logic [tnorm_pkg::LW-1:0]           in_d,
  input  tnorm_pkg::dside_t                  in_side,
  output logic                               out_valid,
  output logic [2:0][tnorm_pkg::QW-1:0]      out_quo,
  output tnorm_pkg::dside_t                  out_side
);
  import tnorm_pkg::*;

  logic                    vld_r [0:QW];
  logic [2:0][LW-1:0]      rem_r [0:QW];
  logic [2:0][QW-1:0]      quo_r [0:QW];
  logic [LW-1:0]           d_r   [0:QW];
  dside_t                  sd_r  [0:QW];

  assign vld_r[0] = in_valid;
  assign d_r[0]   = in_d;
  assign sd_r[0]  = in_side;
  assign quo_r[0] = '0;
  for (genvar k = 0; k < 3; k++) begin : g_init
    assign rem_r[0][k] = LW'(in_mag[k][MW-1:1]);
  end

  for (genvar g = 0; g < QW; g++) begin : g_step
    logic [2:0][LW:0] trial;
    logic [2:0]       ge;

    for (genvar k = 0; k < 3; k++) begin : g_lane
      if (g == 0) begin : g_first
        assign trial[k] = {rem_r[g][k], in_mag[k][0]};
      end else begin : g_rest
        assign trial[k] = {rem_r[g][k], 1'b0};
      end
      assign ge[k] = (trial[k] >= {1'b0, d_r[g]});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else if (en) begin
        vld_r[g+1] <= vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          rem_r[g+1][k] <= ge[k] ? LW'(trial[k] - {1'b0, d_r[g]}) : LW'(trial[k]);
          quo_r[g+1][k] <= {quo_r[g][k][QW-2:0], ge[k]};
        end
        d_r[g+1]  <= d_r[g];
        sd_r[g+1] <= sd_r[g];
      end
    end
  end

  assign out_valid = vld_r[QW];
  assign out_quo   = quo_r[QW];
  assign out_side  = sd_r[QW];

endmodule
`default_nettype wire

// ===== hw/rtl/triangle_unit_normal.sv =====
// Top level: unit face normal of a triangle, fully pipelined.
//
// Takes one triangle (three Q16.16 corners) per cycle and returns its unit
// normal in Q1.30, truncated toward zero, with a degenerate flag when the
// cross product is zero. The pipeline holds six stages of edge, cross
// product and squared-length arithmetic, 66 square root stages (one root bit
// each), 31 divider stages (one quotient bit each) and the output register.
// Throughput is one word per cycle; out_stall holds the whole pipeline.
`default_nettype none
module triangle_unit_normal (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [31:0]       in_a_x,
  input  logic signed [31:0]       in_a_y,
  input  logic signed [31:0]       in_a_z,
  input  logic signed [31:0]       in_b_x,
  input  logic signed [31:0]       in_b_y,
  input  logic signed [31:0]       in_b_z,
  input  logic signed [31:0]       in_c_x,
  input  logic signed [31:0]       in_c_y,
  input  logic signed [31:0]       in_c_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [31:0]       out_normal_x,
  output logic signed [31:0]       out_normal_y,
  output logic signed [31:0]       out_normal_z,
  output logic                     out_degenerate
);
  import tnorm_pkg::*;

  logic en;
  logic signed [CW-1:0] a [3];
  logic signed [CW-1:0] b [3];
  logic signed [CW-1:0] c [3];

  assign a[0] = in_a_x; assign a[1] = in_a_y; assign a[2] = in_a_z;
  assign b[0] = in_b_x; assign b[1] = in_b_y; assign b[2] = in_b_z;
  assign c[0] = in_c_x; assign c[1] = in_c_y; assign c[2] = in_c_z;

  logic                    out_valid_r;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  logic                    v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic signed [EW-1:0]    m_r [3];
  logic signed [EW-1:0]    n_r [3];
  logic signed [PW-1:0]    p_r [3];
  logic signed [PW-1:0]    q_r [3];
  logic [2:0]              neg3_r, neg4_r, neg5_r;
  logic [2:0][MW-1:0]      mag3_r, mag4_r, mag5_r;
  logic [2:0][2*HW-1:0]    hh_r;
  logic [2:0][HW+CW-1:0]   hl_r;
  logic [2:0][2*CW-1:0]    ll_r;
  logic [2:0][SQW-1:0]     sq_r;
  logic [SW-1:0]           s_r;
  side_t                   side6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
      v4_r <= 1'b0; v5_r <= 1'b0; v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r;
      v4_r <= v3_r;     v5_r <= v4_r; v6_r <= v5_r;
    end
  end

  logic signed [PW:0] diff [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = (PW+1)'(p_r[k]) - (PW+1)'(q_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        m_r[k] <= EW'(b[k]) - EW'(a[k]);
        n_r[k] <= EW'(c[k]) - EW'(a[k]);
      end
      p_r[0] <= PW'(m_r[1]) * PW'(n_r[2]);
      q_r[0] <= PW'(m_r[2]) * PW'(n_r[1]);
      p_r[1] <= PW'(m_r[2]) * PW'(n_r[0]);
      q_r[1] <= PW'(m_r[0]) * PW'(n_r[2]);
      p_r[2] <= PW'(m_r[0]) * PW'(n_r[1]);
      q_r[2] <= PW'(m_r[1]) * PW'(n_r[0]);
      for (int k = 0; k < 3; k++) begin
        neg3_r[k] <= diff[k][PW];
        mag3_r[k] <= diff[k][PW] ? MW'(-diff[k]) : MW'(diff[k]);
        hh_r[k]   <= (2*HW)'(mag3_r[k][MW-1:CW]) * (2*HW)'(mag3_r[k][MW-1:CW]);
        hl_r[k]   <= (HW+CW)'(mag3_r[k][MW-1:CW]) * (HW+CW)'(mag3_r[k][CW-1:0]);
        ll_r[k]   <= (2*CW)'(mag3_r[k][CW-1:0]) * (2*CW)'(mag3_r[k][CW-1:0]);
        sq_r[k]   <= {hh_r[k], {(2*CW){1'b0}}} + SQW'({hl_r[k], {(CW+1){1'b0}}})
                     + SQW'(ll_r[k]);
      end
      neg4_r <= neg3_r; mag4_r <= mag3_r;
      neg5_r <= neg4_r; mag5_r <= mag4_r;
      s_r <= SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
      side6_r.neg   <= neg5_r;
      side6_r.mag   <= mag5_r;
      side6_r.degen <= (mag5_r == '0);
    end
  end

  logic               sq_valid;
  logic [LW-1:0]      root;
  side_t              sq_side;

  tnorm_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v6_r),
    .in_sq     (s_r),
    .in_side   (side6_r),
    .out_valid (sq_valid),
    .out_root  (root),
    .out_side  (sq_side)
  );

  dside_t             dv_in;
  logic               dv_valid;
  logic [2:0][QW-1:0] quo;
  dside_t             dv_side;

  assign dv_in.neg   = sq_side.neg;
  assign dv_in.degen = sq_side.degen;

  tnorm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .in_mag    (sq_side.mag),
    .in_d      (root),
    .in_side   (dv_in),
    .out_valid (dv_valid),
    .out_quo   (quo),
    .out_side  (dv_side)
  );

  logic [2:0][CW-1:0] res;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dv_side.degen) begin
        res[k] = '0;
      end else if (dv_side.neg[k]) begin
        res[k] = CW'(0) - CW'(quo[k]);
      end else begin
        res[k] = CW'(quo[k]);
      end
    end
  end

  logic [2:0][CW-1:0] normal_r;
  logic               degen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      normal_r <= res;
      degen_r  <= dv_side.degen;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_normal_x   = normal_r[0];
  assign out_normal_y   = normal_r[1];
  assign out_normal_z   = normal_r[2];
  assign out_degenerate = degen_r;

endmodule
`default_nettype wire
